// ----- rtl/core/tktt_pkg.sv -----
// ----------------------------------------------------------------------------
// Typed-key transaction table package
// Shared request and result types, operation codes, controller states and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tktt_pkg;

    localparam int KEY_BITS      = 32;
    localparam int KIND_BITS     = 2;
    localparam int HANDLE_W      = 8;
    localparam int LIVE_COUNT_W  = 5;

    localparam logic [1:0] FUNC_PUT    = 2'd0;
    localparam logic [1:0] FUNC_FIND   = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]           func;
        logic [KEY_BITS-1:0]  key;
        logic [KIND_BITS-1:0] key_type;
        logic [HANDLE_W-1:0]  handle;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic [HANDLE_W-1:0]     found_handle;
        logic                    inserted;
        logic                    full_drop;
        logic [LIVE_COUNT_W-1:0] live_count;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic scan_start;
        logic scan_rd;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
    } dp_status_t;

endpackage

// ----- rtl/core/tktt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tktt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/tktt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Typed-key transaction table controller
// Sequences the table scan and the commit of each item, and owns the
// request and result handshakes.
// ----------------------------------------------------------------------------
module tktt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output tktt_pkg::ctrl_cmd_t  cmd,
    input  tktt_pkg::dp_status_t status
);

    import tktt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready      = (state_reg == ST_IDLE);
        cmd.scan_start = (state_reg == ST_IDLE) && req_valid;
        cmd.scan_rd    = (state_reg == ST_SCAN);
        // The commit waits until the result register is free or being emptied.
        cmd.commit     = (state_reg == ST_COMMIT) && (!rsp_valid_reg || rsp_ready);
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTHESIS
    a_rsp_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.commit))
        else $error("result appeared without a commit");

    a_last_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAST) |-> ($past(state_reg) == ST_SCAN) && $past(status.scan_last))
        else $error("scan ended before the last slot");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == ST_SCAN))
        else $error("accepted item did not start a scan");
`endif

endmodule

// ----- rtl/core/tktt_dp.sv -----
// ----------------------------------------------------------------------------
// Typed-key transaction table datapath
// Holds the slot RAM, the valid bits and the live count, compares one slot
// per cycle during a scan and applies the operation at commit.
// ----------------------------------------------------------------------------
module tktt_dp #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tktt_pkg::req_t       req,
    input  tktt_pkg::ctrl_cmd_t  cmd,
    output tktt_pkg::dp_status_t status,
    output tktt_pkg::rsp_t       rsp
);

    import tktt_pkg::*;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = KEY_BITS + KIND_BITS + HANDLE_W;

    req_t                   req_reg;
    logic [IDX_W-1:0]       scan_idx_reg;
    logic [IDX_W-1:0]       scan_idx_next;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   rd_live_reg;
    logic                   match_found_reg;
    logic                   match_found_next;
    logic [IDX_W-1:0]       match_idx_reg;
    logic [HANDLE_W-1:0]    match_handle_reg;
    logic                   free_found_reg;
    logic                   free_found_next;
    logic [IDX_W-1:0]       free_idx_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic [ENTRY_W-1:0]     rd_data;
    logic [KEY_BITS-1:0]    rd_key;
    logic [KIND_BITS-1:0]   rd_kind;
    logic [HANDLE_W-1:0]    rd_handle;
    logic                   slot_match;
    logic                   slot_free;
    logic                   do_insert;
    logic                   do_drop;

    tktt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.scan_rd),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    assign rd_key    = rd_data[ENTRY_W-1 -: KEY_BITS];
    assign rd_kind   = rd_data[HANDLE_W +: KIND_BITS];
    assign rd_handle = rd_data[HANDLE_W-1:0];

    // Read data is registered and arrives in the cycle after its address, so the compare uses the
    // delayed index. Only valid slots can match.
    assign slot_match = rd_live_reg && valid_reg[rd_idx_reg]
                        && (rd_key == req_reg.key) && (rd_kind == req_reg.key_type);
    assign slot_free  = rd_live_reg && !valid_reg[rd_idx_reg];

    assign status.scan_last = (scan_idx_reg == IDX_W'(TABLE_DEPTH - 1));

    always_comb
    begin
        if (cmd.scan_start)
        begin
            scan_idx_next    = '0;
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
        end
        else
        begin
            scan_idx_next    = cmd.scan_rd ? scan_idx_reg + IDX_W'(1) : scan_idx_reg;
            match_found_next = match_found_reg || slot_match;
            free_found_next  = free_found_reg || slot_free;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = free_idx_reg;
        wr_data    = {req_reg.key, req_reg.key_type, req_reg.handle};
        do_insert  = 1'b0;
        do_drop    = 1'b0;
        rsp_next   = '0;
        case (req_reg.func)
            FUNC_PUT:
            begin
                rsp_next.hit = match_found_reg;
                if (!match_found_reg)
                begin
                    if (free_found_reg)
                    begin
                        do_insert = 1'b1;
                    end
                    else
                    begin
                        do_drop = 1'b1;
                    end
                end
            end
            FUNC_FIND:
            begin
                rsp_next.hit = match_found_reg;
            end
            FUNC_REMOVE:
            begin
                rsp_next.hit = match_found_reg;
                if (match_found_reg)
                begin
                    wr_en                     = cmd.commit;
                    wr_addr                   = match_idx_reg;
                    wr_data                   = '0;
                    valid_next[match_idx_reg] = 1'b0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                rsp_next.hit = 1'b0;
            end
        endcase
        if (do_insert)
        begin
            wr_en                    = cmd.commit;
            valid_next[free_idx_reg] = 1'b1;
            count_next               = count_reg + CNT_W'(1);
        end
        rsp_next.found_handle = rsp_next.hit ? match_handle_reg : '0;
        rsp_next.inserted     = do_insert;
        rsp_next.full_drop    = do_drop;
        rsp_next.live_count   = LIVE_COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg    <= '0;
            rd_live_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            valid_reg       <= '0;
            count_reg       <= '0;
        end
        else
        begin
            scan_idx_reg    <= scan_idx_next;
            rd_live_reg     <= cmd.scan_rd;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            if (cmd.commit)
            begin
                valid_reg <= valid_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            req_reg <= req;
        end
        if (cmd.scan_rd)
        begin
            rd_idx_reg <= scan_idx_reg;
        end
        // The lowest matching slot and the lowest free slot win.
        if (slot_match && !match_found_reg)
        begin
            match_idx_reg    <= rd_idx_reg;
            match_handle_reg <= rd_handle;
        end
        if (slot_free && !free_found_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("live count disagrees with valid bits");

    a_insert_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && do_insert) |-> !valid_reg[free_idx_reg])
        else $error("insert targets an occupied slot");

    a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && do_drop) |-> (&valid_reg))
        else $error("put dropped while a slot was free");
`endif

endmodule

// ----- rtl/core/typed_key_transaction_table_unit.sv -----
// ----------------------------------------------------------------------------
// Typed-key transaction table
// Fully associative table of handles keyed by a hash and a key kind, with
// put-if-absent, find and remove operations.
// ----------------------------------------------------------------------------
// Each item is handled on its own: after it is accepted the table RAM is
// read one slot per cycle, through every slot, then the controller passes
// its last and commit states and the result is registered at commit; a new
// item is taken only once the controller is back in idle. A waiting result
// does not block acceptance or the scan of the next item; only that item's
// commit waits for the result register to be emptied. Valid bits sit in
// flip-flops cleared by reset, so no clearing pass is needed after reset.
// Matching considers only valid slots, the lowest matching slot wins, and a
// put into a full table stores nothing and reports full_drop.
module typed_key_transaction_table_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  tktt_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output tktt_pkg::rsp_t   rsp
);

    import tktt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tktt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .status    (status)
    );

    tktt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule

// ----- test/tb_typed_key_transaction_table_unit.sv -----
// ----------------------------------------------------------------------------
// Typed-key transaction table testbench
// Drives put, find and remove requests into the table and checks every result
// against a predicted copy of the table. The test starts with a directed
// sequence covering both key extremes, hits, misses, the unused operation and
// a full table. Random traffic follows: it fills and drains the table over a
// small key pool, with random idle cycles on both channels and one long
// back-pressure stretch on the result side.
// ----------------------------------------------------------------------------
module tb_typed_key_transaction_table_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import tktt_pkg::*;

    localparam int DEPTH            = 16;
    localparam int RANDOM_ITEMS     = 2000;
    localparam int POOL_SIZE        = 20;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_AT_RESULT   = 700;
    localparam int PAUSE_AT_ITEM    = 1200;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [KIND_BITS-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_MSG_ID = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_TOKEN  = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_URI    = 2'd3;

    class transaction_table_scoreboard;
        bit                   slot_used[DEPTH];
        logic [KEY_BITS-1:0]  slot_key[DEPTH];
        logic [KIND_BITS-1:0] slot_kind[DEPTH];
        logic [HANDLE_W-1:0]  slot_handle[DEPTH];
        int unsigned          live;
        rsp_t                 awaited_results[$];
        int                   errors;
        int                   checked;
        int                   n_hits;
        int                   n_inserts;
        int                   n_drops;
        int                   n_freed;

        function new();
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_used[i]   = 1'b0;
                slot_key[i]    = '0;
                slot_kind[i]   = '0;
                slot_handle[i] = '0;
            end
            live      = 0;
            errors    = 0;
            checked   = 0;
            n_hits    = 0;
            n_inserts = 0;
            n_drops   = 0;
            n_freed   = 0;
        endfunction

        // Applies one accepted request to the table copy and queues its result.
        function void note_request(req_t r);
            rsp_t exp;
            int   match;
            int   free_slot;
            exp       = '0;
            match     = -1;
            free_slot = -1;
            if (r.func != FUNC_UNUSED)
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (match < 0 && slot_used[i] && slot_key[i] == r.key
                        && slot_kind[i] == r.key_type)
                        match = i;
                end
                if (match >= 0)
                begin
                    exp.hit          = 1'b1;
                    exp.found_handle = slot_handle[match];
                    n_hits++;
                    if (r.func == FUNC_REMOVE)
                    begin
                        slot_used[match]   = 1'b0;
                        slot_key[match]    = '0;
                        slot_kind[match]   = '0;
                        slot_handle[match] = '0;
                        live--;
                        n_freed++;
                    end
                end
                else if (r.func == FUNC_PUT)
                begin
                    for (int i = DEPTH - 1; i >= 0; i--)
                    begin
                        if (!slot_used[i])
                            free_slot = i;
                    end
                    if (free_slot >= 0)
                    begin
                        slot_used[free_slot]   = 1'b1;
                        slot_key[free_slot]    = r.key;
                        slot_kind[free_slot]   = r.key_type;
                        slot_handle[free_slot] = r.handle;
                        live++;
                        exp.inserted = 1'b1;
                        n_inserts++;
                    end
                    else
                    begin
                        exp.full_drop = 1'b1;
                        n_drops++;
                    end
                end
            end
            exp.live_count = LIVE_COUNT_W'(live);
            awaited_results.push_back(exp);
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp;
            bit   bad;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: %p", $time, got);
                errors++;
                return;
            end
            exp = awaited_results.pop_front();
            checked++;
            bad = 1'b0;
            if (got.hit !== exp.hit)
            begin
                $display("%0t: hit expected %0d, got %0d", $time, exp.hit, got.hit);
                bad = 1'b1;
            end
            if (got.found_handle !== exp.found_handle)
            begin
                $display("%0t: found_handle expected 0x%02h, got 0x%02h", $time,
                         exp.found_handle, got.found_handle);
                bad = 1'b1;
            end
            if (got.inserted !== exp.inserted)
            begin
                $display("%0t: inserted expected %0d, got %0d", $time,
                         exp.inserted, got.inserted);
                bad = 1'b1;
            end
            if (got.full_drop !== exp.full_drop)
            begin
                $display("%0t: full_drop expected %0d, got %0d", $time,
                         exp.full_drop, got.full_drop);
                bad = 1'b1;
            end
            if (got.live_count !== exp.live_count)
            begin
                $display("%0t: live_count expected %0d, got %0d", $time,
                         exp.live_count, got.live_count);
                bad = 1'b1;
            end
            if (bad)
                errors++;
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    logic req_ready;
    logic rsp_valid;
    req_t req       = '0;
    rsp_t rsp;

    transaction_table_scoreboard sb;

    logic [KEY_BITS-1:0]  key_pool[POOL_SIZE];
    logic [KIND_BITS-1:0] kind_pool[POOL_SIZE];
    int                   items_sent = 0;

    typed_key_transaction_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(6_000_000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic req_t make_req(logic [1:0] func, logic [KEY_BITS-1:0] key,
                                      logic [KIND_BITS-1:0] kind,
                                      logic [HANDLE_W-1:0] handle);
        req_t r;
        r.func     = func;
        r.key      = key;
        r.key_type = kind;
        r.handle   = handle;
        return r;
    endfunction

    // Mostly pool keys so that finds and removes hit; the mix of operations
    // depends on whether the table is being filled or drained.
    function automatic req_t make_random_request(bit draining);
        req_t r;
        int   roll;
        int   pick;
        roll = $urandom_range(0, 99);
        if (!draining)
            r.func = roll < 55 ? FUNC_PUT : roll < 80 ? FUNC_FIND :
                     roll < 95 ? FUNC_REMOVE : FUNC_UNUSED;
        else
            r.func = roll < 20 ? FUNC_PUT : roll < 45 ? FUNC_FIND :
                     roll < 95 ? FUNC_REMOVE : FUNC_UNUSED;
        if ($urandom_range(0, 99) < 85)
        begin
            pick  = $urandom_range(0, POOL_SIZE - 1);
            r.key = key_pool[pick];
            if ($urandom_range(0, 3) == 0)
                r.key_type = KIND_BITS'($urandom_range(0, 3));
            else
                r.key_type = kind_pool[pick];
        end
        else
        begin
            r.key      = $urandom;
            r.key_type = KIND_BITS'($urandom_range(0, 3));
        end
        r.handle = HANDLE_W'($urandom_range(0, 255));
        return r;
    endfunction

    // Every fourth stretch of 150 items runs back to back.
    function automatic int draw_gap(int index);
        if ((index / 150) % 4 == 3)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    task automatic send_item(req_t r);
        int gap;
        gap = draw_gap(items_sent);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        sb.note_request(r);
        items_sent++;
    endtask

    task automatic idle_until_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (sb.awaited_results.size() != 0);
    endtask

    task automatic drive_results();
        int stall;
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        forever
        begin
            // One long hold-off lets the block fill up and stall its input.
            if (!held && taken == HOLD_AT_RESULT)
            begin
                held  = 1'b1;
                stall = LONG_HOLD_CYCLES;
            end
            else
                stall = draw_gap(taken + 75);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            sb.check_result(rsp);
            taken++;
        end
    endtask

    task automatic run_directed();
        send_item(make_req(FUNC_PUT, 32'h0000_0000, KIND_NONE, 8'h00));
        send_item(make_req(FUNC_PUT, 32'hFFFF_FFFF, KIND_URI, 8'hFF));
        send_item(make_req(FUNC_PUT, 32'hFFFF_FFFF, KIND_URI, 8'h5A));
        send_item(make_req(FUNC_FIND, 32'h0000_0000, KIND_NONE, 8'hFF));
        send_item(make_req(FUNC_FIND, 32'hFFFF_FFFF, KIND_TOKEN, 8'h00));
        send_item(make_req(FUNC_UNUSED, 32'hFFFF_FFFF, KIND_URI, 8'hFF));
        send_item(make_req(FUNC_REMOVE, 32'h0000_0000, KIND_NONE, 8'h00));
        send_item(make_req(FUNC_REMOVE, 32'h0000_0000, KIND_NONE, 8'h00));
        // Same key, other kind: a separate entry in the slot just freed.
        send_item(make_req(FUNC_PUT, 32'hFFFF_FFFF, KIND_MSG_ID, 8'hC3));
        for (int i = 1; i <= DEPTH - 2; i++)
            send_item(make_req(FUNC_PUT, KEY_BITS'(i), KIND_TOKEN, HANDLE_W'(i)));
        send_item(make_req(FUNC_PUT, 32'hA5A5_A5A5, KIND_TOKEN, 8'h77));
        send_item(make_req(FUNC_FIND, 32'hFFFF_FFFF, KIND_MSG_ID, 8'h00));
    endtask

    task automatic run_random();
        bit draining;
        draining = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == PAUSE_AT_ITEM)
                idle_until_drained();
            if (!draining && sb.live == DEPTH && $urandom_range(0, 9) == 0)
                draining = 1'b0 | 1'b1;
            else if (draining && sb.live <= 2 && $urandom_range(0, 3) == 0)
                draining = 1'b0;
            send_item(make_random_request(draining));
        end
    endtask

    initial
    begin
        sb = new();
        key_pool[0]  = 32'h0000_0000;
        kind_pool[0] = KIND_NONE;
        key_pool[1]  = 32'hFFFF_FFFF;
        kind_pool[1] = KIND_URI;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            key_pool[i]  = $urandom;
            kind_pool[i] = KIND_BITS'($urandom_range(0, 3));
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            drive_results();
        join_none

        run_directed();
        idle_until_drained();
        run_random();
        idle_until_drained();
        repeat (40) @(posedge clk);

        $display("%0d requests checked: %0d hits, %0d inserts, %0d full-table drops,",
                 sb.checked, sb.n_hits, sb.n_inserts, sb.n_drops);
        $display("%0d entries removed, with idle gaps and a %0d-cycle result stall.",
                 sb.n_freed, LONG_HOLD_CYCLES);
        if (sb.errors == 0 && sb.awaited_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tktt_pkg.sv
rtl/core/tktt_ram.sv
rtl/core/tktt_ctrl.sv
rtl/core/tktt_dp.sv
rtl/core/typed_key_transaction_table_unit.sv
test/tb_typed_key_transaction_table_unit.sv
